@@ src/sdq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared constants for the spike delay queue: field widths, defaults, codes.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int IDX_W      = 20;   // spike_index, range_start, spike_offset
	localparam int CNT_W      = 21;   // range_count
	localparam int DLY_W      = 6;    // delay_steps
	localparam int KIND_W     = 2;

	localparam int DEF_STORE_DEPTH         = 4096;
	localparam int DEF_MAX_DELAY_STEPS     = 64;
	localparam int DEF_MAX_SPIKES_PER_STEP = 64;
	localparam int DEF_INDEX_BITS          = 20;

	// a query never looks at more than this many entries of one step
	localparam int RESULT_CAP = 64;

	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EOS   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

endpackage

@@ src/sdq_ram.sv @@
// ----------------------------------------------------------------------------
// sdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];   // holds when no read is issued
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/spike_delay_queue_top.sv @@
// ----------------------------------------------------------------------------
// spike_delay_queue_top
// Ring store of spike indices grouped by time step, queried by delay.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (item_valid / item_stall) takes one beat per item; kind
//  selects push spike, end of step, query or clear. Output channel
//  (result_valid / result_stall) returns query results only.
//  Push and clear finish when accepted. End of step makes two reads of
//  the step mark memory, then the commit write.
//  A query fetches the two step marks, then runs two binary searches over
//  the step (up to 7 probes each, a read then a compare on the spike store
//  read port, plus a closing step per search), then emits the spikes; every
//  result is one spike store read followed by a load of the output register.
//  An empty match returns one beat with has_spike low and last_result high.
//  item_stall is high while an item is in progress; the next item is taken
//  once the last result sits in the output register, before it is taken.
//  A stalled receiver holds the output register and pauses the query walk.
//  Reset (arst_n low) empties all steps, clears the cursor and the sticky
//  overflow flag; step marks are cleared at once through per-entry valid
//  bits, so no clearing pass is needed. Spike store contents are not reset.
// ----------------------------------------------------------------------------
module spike_delay_queue_top #(
	parameter int STORE_DEPTH         = sdq_pkg::DEF_STORE_DEPTH,
	parameter int MAX_DELAY_STEPS     = sdq_pkg::DEF_MAX_DELAY_STEPS,
	parameter int MAX_SPIKES_PER_STEP = sdq_pkg::DEF_MAX_SPIKES_PER_STEP,
	parameter int INDEX_BITS          = sdq_pkg::DEF_INDEX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [sdq_pkg::KIND_W-1:0]   kind,
	input  logic [sdq_pkg::IDX_W-1:0]    spike_index,
	input  logic [sdq_pkg::DLY_W-1:0]    delay_steps,
	input  logic [sdq_pkg::IDX_W-1:0]    range_start,
	input  logic [sdq_pkg::CNT_W-1:0]    range_count,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [sdq_pkg::IDX_W-1:0]    spike_offset,
	output logic                         has_spike,
	output logic                         last_result,
	output logic                         overflow_seen
);

	import sdq_pkg::*;

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int MD  = MAX_DELAY_STEPS + 1;
	localparam int MPW = $clog2(MD);
	localparam int SW  = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam int FW  = $clog2(2 * STORE_DEPTH);
	localparam int OW  = $clog2(MAX_SPIKES_PER_STEP + 1);
	localparam int LW  = $clog2(RESULT_CAP + 1);
	localparam int CW  = ((MPW > DLY_W) ? MPW : DLY_W) + 1;
	localparam int KW  = CNT_W + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EOS_A = 4'd1;
	localparam logic [3:0] ST_EOS_B = 4'd2;
	localparam logic [3:0] ST_EOS_C = 4'd3;
	localparam logic [3:0] ST_Q_A   = 4'd4;
	localparam logic [3:0] ST_Q_B   = 4'd5;
	localparam logic [3:0] ST_Q_C   = 4'd6;
	localparam logic [3:0] ST_BS_RD = 4'd7;
	localparam logic [3:0] ST_BS_CP = 4'd8;
	localparam logic [3:0] ST_EM_RD = 4'd9;
	localparam logic [3:0] ST_EM_OUT= 4'd10;
	localparam logic [3:0] ST_EMPTY = 4'd11;

	// wrap a sum below twice the store depth back into the store
	function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= (AW+1)'(STORE_DEPTH)) ? s - (AW+1)'(STORE_DEPTH) : s;
		return r[AW-1:0];
	endfunction

	logic [3:0]      state_q;
	logic [MPW-1:0]  mark_ptr_q;
	logic [AW-1:0]   cursor_q;
	logic [OW-1:0]   open_cnt_q;
	logic [FW-1:0]   free_q;
	logic            ovf_q;
	logic [MD-1:0]   mvalid_q;

	// latched query
	logic [IDX_W-1:0] start_q;
	logic [KW-1:0]    stop_q;
	logic [MPW-1:0]   end_addr_q;
	logic [MPW-1:0]   base_addr_q;
	logic [AW-1:0]    next_val_q;    // EOS: mark at next slot; query: end mark
	logic [AW-1:0]    base_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    lo_q;
	logic [LW-1:0]    hi_q;
	logic [LW-1:0]    first_q;
	logic [LW-1:0]    last_q;
	logic             phase_q;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_off_q;
	logic             out_has_q;
	logic             out_last_q;
	logic             out_ovf_q;

	// mark memory
	logic             m_we;
	logic [MPW-1:0]   m_raddr;
	logic [MPW-1:0]   m_raddr_s1;
	logic             m_re;
	logic [AW-1:0]    m_rdata;
	logic [AW-1:0]    mark_val;

	// spike store
	logic             s_we;
	logic             s_re;
	logic [AW-1:0]    s_raddr;
	logic [SW-1:0]    s_rdata;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic [MPW-1:0]   next_ptr;
	logic [MPW-1:0]   after_ptr;
	logic [CW-1:0]    mp_ext;
	logic [CW-1:0]    dly_ext;
	logic [CW-1:0]    end_ext;
	logic [MPW-1:0]   q_end_addr;
	logic [MPW-1:0]   q_base_addr;
	logic             dly_bad;
	logic             push_drop;
	logic [AW:0]      diff_raw;
	logic [AW-1:0]    diff;
	logic [FW-1:0]    free_sum;
	logic [LW-1:0]    mid;
	logic [LW-1:0]    emit_k;
	logic [KW-1:0]    key;
	logic             probe_lt;
	logic [IDX_W-1:0] spike_ext;

	assign accept   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign load_out = out_free && (state_q == ST_EM_OUT || state_q == ST_EMPTY);

	assign next_ptr  = (mark_ptr_q == MPW'(MD - 1)) ? '0 : mark_ptr_q + 1'b1;
	assign after_ptr = (next_ptr == MPW'(MD - 1)) ? '0 : next_ptr + 1'b1;

	// query slot addresses: end mark delay steps back, base mark one before
	assign mp_ext      = CW'(mark_ptr_q);
	assign dly_ext     = CW'(delay_steps);
	assign dly_bad     = dly_ext >= CW'(MAX_DELAY_STEPS);
	assign end_ext     = (mp_ext >= dly_ext) ? mp_ext - dly_ext : mp_ext + CW'(MD) - dly_ext;
	assign q_end_addr  = end_ext[MPW-1:0];
	assign q_base_addr = (q_end_addr == '0) ? MPW'(MD - 1) : q_end_addr - 1'b1;

	assign push_drop = (open_cnt_q >= OW'(MAX_SPIKES_PER_STEP)) || (free_q <= FW'(1));

	// entries not written since reset or clear read as zero
	assign mark_val = mvalid_q[m_raddr_s1] ? m_rdata : '0;

	// distance between two marks around the ring (next_val_q is the later in a query, the earlier at end of step)
	always_comb begin
		if (state_q == ST_EOS_C) begin
			diff_raw = {1'b0, mark_val} + (AW+1)'(STORE_DEPTH) - {1'b0, next_val_q};
		end else begin
			diff_raw = {1'b0, next_val_q} + (AW+1)'(STORE_DEPTH) - {1'b0, mark_val};
		end
	end
	assign diff     = wrap_addr(diff_raw);
	assign free_sum = free_q + FW'(diff);

	assign mid      = LW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign key      = phase_q ? stop_q : KW'(start_q);
	assign probe_lt = KW'(s_rdata) < key;
	assign emit_k   = lo_q;    // emit walk reuses lo as the cursor
	assign spike_ext = IDX_W'(s_rdata);

	// mark memory control
	always_comb begin
		m_re    = 1'b0;
		m_raddr = next_ptr;
		unique case (state_q)
			ST_EOS_A: begin m_re = 1'b1; m_raddr = next_ptr; end
			ST_EOS_B: begin m_re = 1'b1; m_raddr = after_ptr; end
			ST_Q_A:   begin m_re = 1'b1; m_raddr = end_addr_q; end
			ST_Q_B:   begin m_re = 1'b1; m_raddr = base_addr_q; end
			default:  begin m_re = 1'b0; m_raddr = next_ptr; end
		endcase
	end
	assign m_we = (state_q == ST_EOS_C);

	// spike store control
	assign s_we = accept && (kind == KIND_PUSH) && !push_drop;
	always_comb begin
		s_re    = 1'b0;
		s_raddr = wrap_addr({1'b0, base_q} + (AW+1)'(mid));
		if (state_q == ST_BS_RD && lo_q < hi_q) begin
			s_re = 1'b1;
		end else if (state_q == ST_EM_RD) begin
			s_re    = 1'b1;
			s_raddr = wrap_addr({1'b0, base_q} + (AW+1)'(emit_k));
		end
	end

	always_ff @(posedge clk) begin
		if (m_re) begin
			m_raddr_s1 <= m_raddr;
		end
	end

	sdq_ram #(.WIDTH(AW), .DEPTH(MD)) u_mark_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (next_ptr),
		.wdata (cursor_q),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	sdq_ram #(.WIDTH(SW), .DEPTH(STORE_DEPTH)) u_spike_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (cursor_q),
		.wdata (spike_index[SW-1:0]),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// output beat valid: loaded by the walk, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mark_ptr_q  <= '0;
			cursor_q    <= '0;
			open_cnt_q  <= '0;
			free_q      <= FW'(STORE_DEPTH);
			ovf_q       <= 1'b0;
			mvalid_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_PUSH: begin
								if (push_drop) begin
									ovf_q <= 1'b1;
								end else begin
									cursor_q   <= (cursor_q == AW'(STORE_DEPTH - 1)) ?
										'0 : cursor_q + 1'b1;
									open_cnt_q <= open_cnt_q + 1'b1;
									free_q     <= free_q - 1'b1;
								end
							end
							KIND_EOS:   state_q <= ST_EOS_A;
							KIND_QUERY: state_q <= dly_bad ? ST_EMPTY : ST_Q_A;
							KIND_CLEAR: begin
								mvalid_q   <= '0;
								mark_ptr_q <= '0;
								cursor_q   <= '0;
								open_cnt_q <= '0;
								free_q     <= FW'(STORE_DEPTH);
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EOS_A: state_q <= ST_EOS_B;
				ST_EOS_B: state_q <= ST_EOS_C;
				ST_EOS_C: begin
					// oldest step drops out of reach; hand its space back
					mvalid_q[next_ptr] <= 1'b1;
					mark_ptr_q <= next_ptr;
					free_q     <= (free_sum > FW'(STORE_DEPTH)) ? FW'(STORE_DEPTH) : free_sum;
					open_cnt_q <= '0;
					state_q    <= ST_IDLE;
				end
				ST_Q_A: state_q <= ST_Q_B;
				ST_Q_B: state_q <= ST_Q_C;
				ST_Q_C: state_q <= ST_BS_RD;
				ST_BS_RD: begin
					if (lo_q < hi_q) begin
						state_q <= ST_BS_CP;
					end else if (!phase_q) begin
						state_q <= ST_BS_RD;
					end else if (first_q >= lo_q) begin
						state_q <= ST_EMPTY;
					end else begin
						state_q <= ST_EM_RD;
					end
				end
				ST_BS_CP: state_q <= ST_BS_RD;
				ST_EM_RD: state_q <= ST_EM_OUT;
				ST_EM_OUT: begin
					if (out_free) begin
						state_q <= (lo_q + 1'b1 == last_q) ? ST_IDLE : ST_EM_RD;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			start_q     <= range_start;
			stop_q      <= KW'(range_start) + KW'(range_count);
			end_addr_q  <= q_end_addr;
			base_addr_q <= q_base_addr;
			phase_q     <= 1'b0;
		end
		if (state_q == ST_EOS_B || state_q == ST_Q_B) begin
			next_val_q <= mark_val;
		end
		if (state_q == ST_Q_C) begin
			base_q <= mark_val;
			len_q  <= (diff > AW'(RESULT_CAP)) ? LW'(RESULT_CAP) : LW'(diff);
			lo_q   <= '0;
			hi_q   <= (diff > AW'(RESULT_CAP)) ? LW'(RESULT_CAP) : LW'(diff);
		end
		if (state_q == ST_BS_RD && !(lo_q < hi_q)) begin
			if (!phase_q) begin
				first_q <= lo_q;
				hi_q    <= len_q;
				phase_q <= 1'b1;
			end else begin
				last_q <= lo_q;
				lo_q   <= first_q;
			end
		end
		if (state_q == ST_BS_CP) begin
			if (probe_lt) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
		end
		if (state_q == ST_EM_OUT && out_free) begin
			out_off_q  <= spike_ext - start_q;
			out_has_q  <= 1'b1;
			out_last_q <= (lo_q + 1'b1 == last_q);
			out_ovf_q  <= ovf_q;
			lo_q       <= lo_q + 1'b1;
		end
		if (state_q == ST_EMPTY && out_free) begin
			out_off_q  <= '0;
			out_has_q  <= 1'b0;
			out_last_q <= 1'b1;
			out_ovf_q  <= ovf_q;
		end
	end

	assign item_stall    = (state_q != ST_IDLE);
	assign result_valid  = out_valid_q;
	assign spike_offset  = out_off_q;
	assign has_spike     = out_has_q;
	assign last_result   = out_last_q;
	assign overflow_seen = out_ovf_q;

endmodule

@@ src/sdq_checker.sv @@
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks on the result channel of the spike delay queue.
// ----------------------------------------------------------------------------
module sdq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [sdq_pkg::IDX_W-1:0]   spike_offset,
	input logic                        has_spike,
	input logic                        last_result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(spike_offset) && $stable(last_result))
		else $error("result beat changed under stall");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_spike |-> last_result)
		else $error("empty answer not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_spike |-> spike_offset == '0)
		else $error("empty answer carries an offset");

endmodule

bind spike_delay_queue_top sdq_checker u_sdq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.spike_offset (spike_offset),
	.has_spike    (has_spike),
	.last_result  (last_result)
);
